/* rtl/tabular_q_learning_update_defines.svh */
// ---------------------------------------------------------------------------
// tabular q-learning update: assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH

// same-cycle implication
`define TQL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TQL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tql_pkg.sv */
// ---------------------------------------------------------------------------
// tql_pkg
// shared sizes, codes and types of the tabular q-learning update engine
// ---------------------------------------------------------------------------
package tql_pkg;

	localparam int NUM_STATES = 8;
	localparam int Q_BITS     = 16;

	localparam int FIELD_W   = 3;
	localparam int REW_W     = 11;
	localparam int DISC_W    = 16;
	localparam int QV_W      = 16;
	localparam int STATE_W   = $clog2(NUM_STATES);
	localparam int TBL_DEPTH = NUM_STATES * NUM_STATES;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int PROD_W    = Q_BITS + DISC_W;
	localparam int SUM_W     = ((Q_BITS > REW_W) ? Q_BITS : REW_W) + 2;

	localparam logic [Q_BITS-1:0]       Q_MAX          = '1;
	localparam logic signed [REW_W-1:0] REWARD_NO_PATH = -11'sd1;

	localparam logic [DISC_W-1:0]  DISCOUNT_RST = 16'd58982;
	localparam logic [FIELD_W-1:0] GOAL_RST     = 3'd5;

	// request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_LEARN = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DISCOUNT = 2'd0;
	localparam logic [1:0] CFG_GOAL     = 2'd1;

	typedef logic [ADDR_W-1:0] tbl_addr_t;

	typedef struct packed {
		logic                     q_we;
		tbl_addr_t                q_waddr;
		logic [Q_BITS-1:0]        q_wdata;
		tbl_addr_t                q_raddr;
		logic                     r_we;
		tbl_addr_t                r_waddr;
		logic signed [REW_W-1:0]  r_wdata;
		tbl_addr_t                r_raddr;
	} mem_req_t;

	typedef struct packed {
		logic [Q_BITS-1:0]        q_rdata;
		logic signed [REW_W-1:0]  r_rdata;
	} mem_rsp_t;

	// low result bits of a q entry, zero filled when the entry is narrower
	function automatic logic [QV_W-1:0] to_qv(input logic [Q_BITS-1:0] q);
		logic [Q_BITS+QV_W-1:0] t;
		t = {{QV_W{1'b0}}, q};
		return t[QV_W-1:0];
	endfunction

endpackage

/* rtl/tql_mem.sv */
// ---------------------------------------------------------------------------
// tql_mem
// q table and reward table, one write and one registered read port each,
// per-entry valid bits give the reset contents
// ---------------------------------------------------------------------------
module tql_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  tql_pkg::mem_req_t req,
	output tql_pkg::mem_rsp_t rsp
);
	import tql_pkg::*;

	logic [Q_BITS-1:0]       q_mem [TBL_DEPTH];
	logic signed [REW_W-1:0] r_mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]    q_vld_q;
	logic [TBL_DEPTH-1:0]    r_vld_q;
	logic [Q_BITS-1:0]       q_rd_q;
	logic signed [REW_W-1:0] r_rd_q;
	logic                    q_rv_q;
	logic                    r_rv_q;

	always_ff @(posedge clk) begin
		if (req.q_we) begin
			q_mem[req.q_waddr] <= req.q_wdata;
		end
		if (req.r_we) begin
			r_mem[req.r_waddr] <= req.r_wdata;
		end
		q_rd_q <= q_mem[req.q_raddr];
		r_rd_q <= r_mem[req.r_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_q <= '0;
			r_vld_q <= '0;
			q_rv_q  <= 1'b0;
			r_rv_q  <= 1'b0;
		end else begin
			if (req.q_we) begin
				q_vld_q[req.q_waddr] <= 1'b1;
			end
			if (req.r_we) begin
				r_vld_q[req.r_waddr] <= 1'b1;
			end
			q_rv_q <= q_vld_q[req.q_raddr];
			r_rv_q <= r_vld_q[req.r_raddr];
		end
	end

	// unwritten entries read as their reset values
	assign rsp.q_rdata = q_rv_q ? q_rd_q : '0;
	assign rsp.r_rdata = r_rv_q ? r_rd_q : REWARD_NO_PATH;

endmodule

/* rtl/tql_engine.sv */
// ---------------------------------------------------------------------------
// tql_engine
// request sequencer: row maximum walk, discount multiply, saturating add
// ---------------------------------------------------------------------------
module tql_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [1:0]                            req_type,
	input  logic [tql_pkg::FIELD_W-1:0]           from_state,
	input  logic [tql_pkg::FIELD_W-1:0]           action,
	input  logic signed [tql_pkg::REW_W-1:0]      reward_value,
	input  logic [tql_pkg::DISC_W-1:0]            discount,
	input  logic [tql_pkg::FIELD_W-1:0]           goal_state,
	input  tql_pkg::mem_rsp_t                     mem_rsp,
	output tql_pkg::mem_req_t                     mem_req,
	output logic                                  busy,
	output logic                                  done,
	output logic [tql_pkg::QV_W-1:0]              q_value,
	output logic [tql_pkg::FIELD_W-1:0]           next_state,
	output logic                                  goal_reached,
	output logic                                  no_path
);
	import tql_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RDOUT,
		S_RCHK,
		S_SCAN,
		S_LAST,
		S_MUL,
		S_SUM
	} state_t;

	state_t                  state_q;
	logic                    busy_q;
	logic                    done_q;
	logic [QV_W-1:0]         qv_q;
	logic [FIELD_W-1:0]      ns_q;
	logic                    goal_q;
	logic                    nop_q;
	logic [STATE_W-1:0]      j_q;
	logic                    cmp_vld_q;

	logic [1:0]              req_q;
	logic [FIELD_W-1:0]      from_q;
	logic [FIELD_W-1:0]      act_q;
	logic signed [REW_W-1:0] rew_q;
	logic [Q_BITS-1:0]       best_q;
	logic [PROD_W-1:0]       prod_q;

	logic                    in_range;
	tbl_addr_t               idx;
	tbl_addr_t               row_addr;
	logic [Q_BITS-1:0]       prod_hi;
	logic signed [SUM_W-1:0] sum;
	logic [Q_BITS-1:0]       nv;
	logic                    at_goal;

	assign in_range = (32'(from_q) < NUM_STATES) && (32'(act_q) < NUM_STATES);
	assign idx      = ADDR_W'(32'(from_q) * NUM_STATES + 32'(act_q));
	assign row_addr = ADDR_W'(32'(act_q) * NUM_STATES + 32'(j_q));
	assign at_goal  = (act_q == goal_state);

	// fraction of the product dropped, reward added as an integer
	assign prod_hi = prod_q[PROD_W-1:DISC_W];
	assign sum     = SUM_W'(rew_q) + $signed(SUM_W'(prod_hi));

	always_comb begin
		if (sum[SUM_W-1]) begin
			nv = '0;
		end else if (|sum[SUM_W-2:Q_BITS]) begin
			nv = Q_MAX;
		end else begin
			nv = sum[Q_BITS-1:0];
		end
	end

	always_comb begin
		mem_req         = '0;
		mem_req.r_raddr = idx;
		mem_req.r_waddr = idx;
		mem_req.r_wdata = rew_q;
		mem_req.q_waddr = idx;
		mem_req.q_wdata = nv;
		mem_req.q_raddr = (state_q == S_SCAN) ? row_addr : idx;
		mem_req.r_we    = (state_q == S_DECODE) && (req_q == REQ_LOAD) && in_range;
		mem_req.q_we    = (state_q == S_SUM);
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_q  <= req_type;
			from_q <= from_state;
			act_q  <= action;
			rew_q  <= reward_value;
		end
		if (state_q == S_RCHK) begin
			rew_q <= mem_rsp.r_rdata;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(discount) * PROD_W'(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			qv_q      <= '0;
			ns_q      <= '0;
			goal_q    <= 1'b0;
			nop_q     <= 1'b0;
			j_q       <= '0;
			cmp_vld_q <= 1'b0;
			best_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (req_q)
						REQ_LEARN: begin
							state_q <= S_RCHK;
						end
						REQ_READ: begin
							state_q <= S_RDOUT;
						end
						default: begin
							// load, or a code with no meaning: empty word
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							qv_q    <= '0;
							ns_q    <= '0;
							goal_q  <= 1'b0;
							nop_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RDOUT: begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					qv_q    <= in_range ? to_qv(mem_rsp.q_rdata) : '0;
					ns_q    <= '0;
					goal_q  <= 1'b0;
					nop_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				S_RCHK: begin
					if (!in_range || (mem_rsp.r_rdata == REWARD_NO_PATH)) begin
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						qv_q    <= '0;
						ns_q    <= act_q;
						goal_q  <= at_goal;
						nop_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						j_q       <= '0;
						cmp_vld_q <= 1'b0;
						best_q    <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read one entry per cycle, compare the one read last cycle
					if (cmp_vld_q && (mem_rsp.q_rdata > best_q)) begin
						best_q <= mem_rsp.q_rdata;
					end
					cmp_vld_q <= 1'b1;
					j_q       <= j_q + STATE_W'(1);
					if (j_q == STATE_W'(NUM_STATES - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (mem_rsp.q_rdata > best_q) begin
						best_q <= mem_rsp.q_rdata;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					qv_q    <= to_qv(nv);
					ns_q    <= act_q;
					goal_q  <= at_goal;
					nop_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign q_value      = qv_q;
	assign next_state   = ns_q;
	assign goal_reached = goal_q;
	assign no_path      = nop_q;

endmodule

/* rtl/tabular_q_learning_update.sv */
// ---------------------------------------------------------------------------
// tabular_q_learning_update
// q-learning update engine over a reward table and a q table
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the one result word of that request appears on the result ports with
// done high for a single cycle. The receiver cannot stall: the word must be
// captured in that cycle. A load or an unknown request goes through decode
// only, a read through decode and the q read, a learn step through decode,
// the reward check and the walk over the next state's q row, one entry per
// cycle through the single read port of the q memory, then a multiply step
// and an add/saturate/write step; a learn step that flags no_path ends
// after the reward check. A new request may be taken in the cycle that
// shows done. Both tables read as their reset values from reset on, with no
// clearing pass. Configuration writes are always accepted (cfg_ready high);
// the user must keep them to idle periods only; the block does not check.
// ---------------------------------------------------------------------------
module tabular_q_learning_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [tql_pkg::FIELD_W-1:0]       from_state,
	input  logic [tql_pkg::FIELD_W-1:0]       action,
	input  logic signed [tql_pkg::REW_W-1:0]  reward_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [tql_pkg::DISC_W-1:0]        cfg_data,
	output logic                              done,
	output logic [tql_pkg::QV_W-1:0]          q_value,
	output logic [tql_pkg::FIELD_W-1:0]       next_state,
	output logic                              goal_reached,
	output logic                              no_path
);
	import tql_pkg::*;

	logic [DISC_W-1:0]  discount_q;
	logic [FIELD_W-1:0] goal_q;
	mem_req_t           mem_req;
	mem_rsp_t           mem_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q <= DISCOUNT_RST;
			goal_q     <= GOAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DISCOUNT: discount_q <= cfg_data;
				CFG_GOAL:     goal_q     <= cfg_data[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	tql_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.from_state   (from_state),
		.action       (action),
		.reward_value (reward_value),
		.discount     (discount_q),
		.goal_state   (goal_q),
		.mem_rsp      (mem_rsp),
		.mem_req      (mem_req),
		.busy         (busy),
		.done         (done),
		.q_value      (q_value),
		.next_state   (next_state),
		.goal_reached (goal_reached),
		.no_path      (no_path)
	);

	tql_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

endmodule

/* rtl/tql_checker.sv */
// ---------------------------------------------------------------------------
// tql_checker
// port-level checks of the request/result sequencing
// ---------------------------------------------------------------------------
`include "tabular_q_learning_update_defines.svh"

module tql_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     done,
	input  logic [tql_pkg::QV_W-1:0] q_value,
	input  logic                     no_path
);
	import tql_pkg::*;

	logic accept;

	assign accept = start && !busy;

	`TQL_ASSERT_NXT(a_busy_after_accept, accept, busy, "busy not raised after accept")
	`TQL_ASSERT_NOW(a_done_ends_busy, done, $past(busy) && !busy, "done without a busy request")
	`TQL_ASSERT_NXT(a_done_single, done, !done, "done held longer than one cycle")
	`TQL_ASSERT_NOW(a_no_path_zero, done && no_path, q_value == '0, "no_path word with a q value")

endmodule

bind tabular_q_learning_update tql_checker u_chk (.*);
